[hdl/brl_pkg.sv]
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types and constants for the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package brl_pkg;

    // Default coordinate width (4 to 16)
    localparam int COORD_BITS_DEF = 12;

    // Fixed field widths
    localparam int PITCH_W  = 13;
    localparam int INDEX_W  = 24;
    localparam int COLOR_W  = 32;

    // Line pitch after reset
    localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd1024;

    // Input item modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // Control of the walker stage register
    typedef struct packed {
        logic vld;        // stage holds an item
        logic pix_valid;  // item carries a pixel
        logic last;       // line finished after this item
    } t_s1_ctl;

endpackage

[hdl/brl_if.sv]
// ----------------------------------------------------------------------------
// brl_in_if / brl_out_if
// Valid/ready channels for line commands and pixel results.
// ----------------------------------------------------------------------------
interface brl_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] stop_x;
    logic [COORD_BITS-1:0] stop_y;
    logic [31:0]           pixel_color;

    modport source (output valid, mode, start_x, start_y, stop_x, stop_y, pixel_color,
                    input ready);
    modport sink   (input valid, mode, start_x, start_y, stop_x, stop_y, pixel_color,
                    output ready);
endinterface

interface brl_out_if;
    logic        valid;
    logic        ready;
    logic        pixel_valid;
    logic [23:0] pixel_index;
    logic [31:0] out_color;
    logic        last_pixel;

    modport source (output valid, pixel_valid, pixel_index, out_color, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_valid, pixel_index, out_color, last_pixel,
                    output ready);
endinterface

[hdl/brl_walker.sv]
// ----------------------------------------------------------------------------
// brl_walker
// Line state and one Bresenham update per accepted item; registers the
// pixel position, color and flags into the walker stage.
// ----------------------------------------------------------------------------
module brl_walker #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_s1_take,
    input  logic                    i_mode,
    input  logic [COORD_BITS-1:0]   i_start_x,
    input  logic [COORD_BITS-1:0]   i_start_y,
    input  logic [COORD_BITS-1:0]   i_stop_x,
    input  logic [COORD_BITS-1:0]   i_stop_y,
    input  logic [31:0]             i_color,
    output brl_pkg::t_s1_ctl        o_s1_ctl,
    output logic [COORD_BITS-1:0]   o_s1_x,
    output logic [COORD_BITS-1:0]   o_s1_y,
    output logic [31:0]             o_s1_color
);
    import brl_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = CB + 2;   // error accumulator
    localparam int CW = CB + 3;   // compare width for 2*error

    // Line state
    logic [CB-1:0]        r_cur_x, r_cur_y, r_end_x, r_end_y, r_mag_dx, r_mag_dy;
    logic                 r_dir_x_neg, r_dir_y_neg, r_busy;
    logic signed [EW-1:0] r_err;
    logic [31:0]          r_color;

    logic [CB-1:0]        n_cur_x, n_cur_y, n_end_x, n_end_y, n_mag_dx, n_mag_dy;
    logic                 n_dir_x_neg, n_dir_y_neg, n_busy;
    logic signed [EW-1:0] n_err;
    logic [31:0]          n_color;

    // Walker stage
    t_s1_ctl       r_s1_ctl, n_s1_ctl;
    logic [CB-1:0] r_s1_x, r_s1_y, n_s1_x, n_s1_y;
    logic [31:0]   r_s1_color, n_s1_color;

    // Step tests on 2*error
    function automatic logic x_steps(logic signed [EW-1:0] err, logic [CB-1:0] mdy);
        logic signed [CW-1:0] e2;
        logic signed [CW-1:0] ndy;
        e2  = {err, 1'b0};
        ndy = -$signed({3'b000, mdy});
        return e2 >= ndy;
    endfunction

    function automatic logic y_steps(logic signed [EW-1:0] err, logic [CB-1:0] mdx);
        logic signed [CW-1:0] e2;
        e2 = {err, 1'b0};
        return e2 <= $signed({3'b000, mdx});
    endfunction

    logic          deg;
    logic          s_xlt, s_ylt;
    logic [CB-1:0] s_dx, s_dy;
    logic          a_xs, a_ys, last;

    always_comb begin
        // Start decode
        s_xlt = i_start_x < i_stop_x;
        s_ylt = i_start_y < i_stop_y;
        s_dx  = s_xlt ? i_stop_x - i_start_x : i_start_x - i_stop_x;
        s_dy  = s_ylt ? i_stop_y - i_start_y : i_start_y - i_stop_y;
        deg   = (i_start_x == i_stop_x) && (i_start_y == i_stop_y);

        // Hold by default
        n_cur_x = r_cur_x;   n_cur_y = r_cur_y;
        n_end_x = r_end_x;   n_end_y = r_end_y;
        n_mag_dx = r_mag_dx; n_mag_dy = r_mag_dy;
        n_dir_x_neg = r_dir_x_neg; n_dir_y_neg = r_dir_y_neg;
        n_err = r_err; n_color = r_color; n_busy = r_busy;

        a_xs = x_steps(r_err, r_mag_dy);
        a_ys = y_steps(r_err, r_mag_dx);
        last = 1'b1;

        // Empty result unless a pixel is produced
        n_s1_ctl.pix_valid = 1'b0;
        n_s1_ctl.last      = 1'b1;
        n_s1_x     = '0;
        n_s1_y     = '0;
        n_s1_color = '0;

        if (i_mode == MODE_START) begin
            if (deg) begin
                n_busy = 1'b0;
            end else begin
                n_cur_x = i_start_x;  n_cur_y = i_start_y;
                n_end_x = i_stop_x;   n_end_y = i_stop_y;
                n_mag_dx = s_dx;      n_mag_dy = s_dy;
                n_dir_x_neg = !s_xlt; n_dir_y_neg = !s_ylt;
                n_err = $signed({2'b00, s_dx}) - $signed({2'b00, s_dy});
                n_color = i_color;
            end
        end else if (r_busy) begin
            // Advance one Bresenham step
            if (a_xs) begin
                n_cur_x = r_dir_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
            end
            if (a_ys) begin
                n_cur_y = r_dir_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
            end
            n_err = r_err - (a_xs ? $signed({2'b00, r_mag_dy}) : '0)
                          + (a_ys ? $signed({2'b00, r_mag_dx}) : '0);
        end

        // Emit the pixel at the new position and check for the end of the walk
        if ((i_mode == MODE_START && !deg) || (i_mode == MODE_STEP && r_busy)) begin
            last = ((n_cur_x == n_end_x) && (n_cur_y == n_end_y))
                || (x_steps(n_err, n_mag_dy) && (n_cur_x == n_end_x))
                || (y_steps(n_err, n_mag_dx) && (n_cur_y == n_end_y));
            n_busy = !last;
            n_s1_ctl.pix_valid = 1'b1;
            n_s1_ctl.last      = last;
            n_s1_x     = n_cur_x;
            n_s1_y     = n_cur_y;
            n_s1_color = n_color;
        end

        n_s1_ctl.vld = i_accept ? 1'b1 : (i_s1_take ? 1'b0 : r_s1_ctl.vld);
    end

    // Update state on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0; r_cur_y <= '0; r_end_x <= '0; r_end_y <= '0;
            r_mag_dx <= '0; r_mag_dy <= '0;
            r_dir_x_neg <= 1'b0; r_dir_y_neg <= 1'b0;
            r_err <= '0; r_color <= '0; r_busy <= 1'b0;
        end else if (i_accept) begin
            r_cur_x <= n_cur_x; r_cur_y <= n_cur_y;
            r_end_x <= n_end_x; r_end_y <= n_end_y;
            r_mag_dx <= n_mag_dx; r_mag_dy <= n_mag_dy;
            r_dir_x_neg <= n_dir_x_neg; r_dir_y_neg <= n_dir_y_neg;
            r_err <= n_err; r_color <= n_color; r_busy <= n_busy;
        end
    end

    // Walker stage valid and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl.vld <= n_s1_ctl.vld;
            if (i_accept) begin
                r_s1_ctl.pix_valid <= n_s1_ctl.pix_valid;
                r_s1_ctl.last      <= n_s1_ctl.last;
            end
        end
    end

    // Walker stage payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_x     <= n_s1_x;
            r_s1_y     <= n_s1_y;
            r_s1_color <= n_s1_color;
        end
    end

    assign o_s1_ctl   = r_s1_ctl;
    assign o_s1_x     = r_s1_x;
    assign o_s1_y     = r_s1_y;
    assign o_s1_color = r_s1_color;

endmodule

[hdl/brl_index.sv]
// ----------------------------------------------------------------------------
// brl_index
// Linear address x + y * pitch and the result register of the output channel.
// ----------------------------------------------------------------------------
module brl_index #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_out_move,
    input  logic [brl_pkg::PITCH_W-1:0]    i_pitch,
    input  brl_pkg::t_s1_ctl               i_s1_ctl,
    input  logic [COORD_BITS-1:0]          i_s1_x,
    input  logic [COORD_BITS-1:0]          i_s1_y,
    input  logic [brl_pkg::COLOR_W-1:0]    i_s1_color,
    output logic                           o_valid,
    output logic                           o_pixel_valid,
    output logic [brl_pkg::INDEX_W-1:0]    o_pixel_index,
    output logic [brl_pkg::COLOR_W-1:0]    o_out_color,
    output logic                           o_last_pixel
);
    import brl_pkg::*;

    // Product width, never narrower than the index
    localparam int PW = (COORD_BITS + PITCH_W + 1 > INDEX_W) ?
                        COORD_BITS + PITCH_W + 1 : INDEX_W;

    logic [PW-1:0]      addr;
    logic               r_valid, r_pix_valid, r_last;
    logic [INDEX_W-1:0] r_index;
    logic [COLOR_W-1:0] r_color;

    // Address from walker stage
    assign addr = PW'(i_s1_y) * PW'(i_pitch) + PW'(i_s1_x);

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_out_move) begin
            r_valid <= i_s1_ctl.vld;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_out_move && i_s1_ctl.vld) begin
            r_pix_valid <= i_s1_ctl.pix_valid;
            r_last      <= i_s1_ctl.last;
            r_index     <= i_s1_ctl.pix_valid ? addr[INDEX_W-1:0] : '0;
            r_color     <= i_s1_color;
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel_valid = r_pix_valid;
    assign o_pixel_index = r_index;
    assign o_out_color   = r_color;
    assign o_last_pixel  = r_last;

endmodule

[hdl/bresenham_line_raster_top.sv]
// ----------------------------------------------------------------------------
// bresenham_line_raster_top
// Bresenham line walker producing linear framebuffer pixel items.
//
//   channel   dir   handshake      contents
//   i_line    in    valid/ready    mode, start/stop endpoints, pixel_color
//   o_pix     out   valid/ready    pixel_valid, pixel_index, out_color, last_pixel
//   i_cfg_*   in    write enable   line_pitch (13 bits)
//
// One item per cycle sustained while o_pix.ready is high.
// Stage one runs the error update and end test, stage two the pitch multiply.
// Reset (synchronous, active low) idles the walker and sets pitch to 1024.
// A stalled output holds both stages; i_line.ready drops only when both are
// full and o_pix.ready is low.
// ----------------------------------------------------------------------------
module bresenham_line_raster_top #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [brl_pkg::PITCH_W-1:0]  i_cfg_wdata,
    brl_in_if.sink                       i_line,
    brl_out_if.source                    o_pix
);
    import brl_pkg::*;

    logic [PITCH_W-1:0]    r_pitch;
    t_s1_ctl               s1_ctl;
    logic [COORD_BITS-1:0] s1_x, s1_y;
    logic [COLOR_W-1:0]    s1_color;
    logic                  out_move, s1_free, accept;

    // Pitch register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= PITCH_RESET;
        end else if (i_cfg_we) begin
            r_pitch <= i_cfg_wdata;
        end
    end

    // Pipeline flow
    assign out_move     = !o_pix.valid || o_pix.ready;
    assign s1_free      = !s1_ctl.vld || out_move;
    assign i_line.ready = s1_free;
    assign accept       = i_line.valid && s1_free;

    brl_walker #(.COORD_BITS(COORD_BITS)) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_s1_take  (out_move),
        .i_mode     (i_line.mode),
        .i_start_x  (i_line.start_x),
        .i_start_y  (i_line.start_y),
        .i_stop_x   (i_line.stop_x),
        .i_stop_y   (i_line.stop_y),
        .i_color    (i_line.pixel_color),
        .o_s1_ctl   (s1_ctl),
        .o_s1_x     (s1_x),
        .o_s1_y     (s1_y),
        .o_s1_color (s1_color)
    );

    brl_index #(.COORD_BITS(COORD_BITS)) u_index (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_out_move    (out_move),
        .i_pitch       (r_pitch),
        .i_s1_ctl      (s1_ctl),
        .i_s1_x        (s1_x),
        .i_s1_y        (s1_y),
        .i_s1_color    (s1_color),
        .o_valid       (o_pix.valid),
        .o_pixel_valid (o_pix.pixel_valid),
        .o_pixel_index (o_pix.pixel_index),
        .o_out_color   (o_pix.out_color),
        .o_last_pixel  (o_pix.last_pixel)
    );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Bresenham line rasterizer.
// Feeds line commands (starts, steps, degenerate and abandoned lines) through
// the valid/ready input channel with random gaps, and back-pressures the pixel
// channel at random and once for a long stretch. An in-bench walker model
// predicts each pixel item. Results are compared in order, field by field.
// The line pitch is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brl_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int COORD_MAX   = (1 << CB) - 1;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 170;

    typedef struct {
        logic          mode;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
        logic [31:0]   color;
    } t_line_cmd;

    typedef struct {
        logic               pix_valid;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel_res;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [PITCH_W-1:0] i_cfg_wdata;

    brl_in_if #(.COORD_BITS(CB)) line_if ();
    brl_out_if                   pix_if ();

    bresenham_line_raster_top #(.COORD_BITS(CB)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_line      (line_if),
        .o_pix       (pix_if)
    );

    // Command items waiting for the driver, and pixel items still owed.
    t_line_cmd  pending_cmds[$];
    t_pixel_res expected_pixels[$];

    // Walker model state
    logic [PITCH_W-1:0] pitch_model = PITCH_RESET;
    logic [CB-1:0]      w_x, w_y, w_end_x, w_end_y;
    int                 w_dx, w_dy, w_err;
    logic               w_neg_x, w_neg_y;
    logic [31:0]        w_color;
    logic               w_busy;

    // Bookkeeping
    logic line_taken = 1'b0;
    int   items_sent = 0;
    int   starts_sent = 0;
    int   results_seen = 0;
    int   pixels_seen = 0;
    int   empties_seen = 0;
    int   line_ends = 0;
    int   fail_cnt = 0;
    int   stall_cycles = 0;
    int   items_queued = 0;
    int   pitches_used = 1;
    int   hold_left = 0;
    logic pressure_done = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Advance the walker by one command item and return the pixel it gives.
    function automatic t_pixel_res walk_predict(input t_line_cmd c);
        t_pixel_res r;
        int         e2;
        r.pix_valid = 1'b0;
        r.index     = '0;
        r.color     = '0;
        r.last      = 1'b1;
        if (c.mode == MODE_START) begin
            if (c.sx == c.ex && c.sy == c.ey) begin
                w_busy = 1'b0;
                return r;
            end
            w_x     = c.sx;
            w_y     = c.sy;
            w_end_x = c.ex;
            w_end_y = c.ey;
            w_neg_x = !(c.sx < c.ex);
            w_neg_y = !(c.sy < c.ey);
            w_dx    = (c.sx < c.ex) ? int'(c.ex) - int'(c.sx) : int'(c.sx) - int'(c.ex);
            w_dy    = (c.sy < c.ey) ? int'(c.ey) - int'(c.sy) : int'(c.sy) - int'(c.ey);
            w_err   = w_dx - w_dy;
            w_color = c.color;
        end else if (!w_busy) begin
            return r;
        end else begin
            e2 = 2 * w_err;
            if (e2 >= -w_dy) begin
                w_err = w_err - w_dy;
                w_x   = w_neg_x ? w_x - 1'b1 : w_x + 1'b1;
            end
            if (e2 <= w_dx) begin
                w_err = w_err + w_dx;
                w_y   = w_neg_y ? w_y - 1'b1 : w_y + 1'b1;
            end
        end
        // End test on the pixel being given: endpoint, or an exit check fires
        e2 = 2 * w_err;
        r.last = (w_x == w_end_x && w_y == w_end_y) ||
                 (e2 >= -w_dy && w_x == w_end_x) ||
                 (e2 <= w_dx && w_y == w_end_y);
        r.pix_valid = 1'b1;
        r.index     = INDEX_W'(64'(w_x) + 64'(w_y) * 64'(pitch_model));
        r.color     = w_color;
        w_busy      = !r.last;
        return r;
    endfunction

    task automatic add_cmd(input logic mode, input int sx, input int sy, input int ex,
                           input int ey, input logic [31:0] color);
        t_line_cmd c;
        c.mode  = mode;
        c.sx    = CB'(sx);
        c.sy    = CB'(sy);
        c.ex    = CB'(ex);
        c.ey    = CB'(ey);
        c.color = color;
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    // Step items carry random endpoint and color bits, which the block ignores.
    task automatic add_steps(input int n);
        repeat (n) add_cmd(MODE_STEP, $urandom_range(0, COORD_MAX),
                           $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, COORD_MAX), $urandom());
    endtask

    task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                            input int steps);
        add_cmd(MODE_START, sx, sy, ex, ey, $urandom());
        add_steps(steps);
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic int line_span(input int sx, input int sy, input int ex, input int ey);
        int ax;
        int ay;
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        return (ax > ay) ? ax : ay;
    endfunction

    // Queue one phase of random traffic, mostly complete short lines.
    task automatic fill_random(input int n);
        int target;
        int kind;
        int sx, sy, ex, ey, span;
        target = items_queued + n;
        while (items_queued < target) begin
            kind = $urandom_range(0, 99);
            sx   = $urandom_range(0, COORD_MAX);
            sy   = $urandom_range(0, COORD_MAX);
            ex   = clamp_coord(sx + $urandom_range(0, 24) - 12);
            ey   = clamp_coord(sy + $urandom_range(0, 24) - 12);
            span = line_span(sx, sy, ex, ey);
            if (kind < 70) begin
                // complete line, sometimes walked past its end
                add_line(sx, sy, ex, ey, span + (($urandom_range(0, 4) == 0) ?
                         $urandom_range(1, 2) : 0));
            end else if (kind < 80) begin
                // long line, abandoned early
                add_line(sx, sy, $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(1, 30));
            end else if (kind < 90) begin
                // noise: degenerate start or stray steps
                if ($urandom_range(0, 1) == 0)
                    add_cmd(MODE_START, sx, sy, sx, sy, $urandom());
                else
                    add_steps($urandom_range(1, 3));
            end else begin
                // truncated line, cut off by the next start
                add_line(sx, sy, ex, ey, (span > 1) ? $urandom_range(0, span - 1) : 0);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_pitch(input logic [PITCH_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        pitch_model = value;
        pitches_used++;
        @(posedge i_clk);
    endtask

    // Stimulus and end of run
    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        line_if.valid       = 1'b0;
        line_if.mode        = MODE_START;
        line_if.start_x     = '0;
        line_if.start_y     = '0;
        line_if.stop_x      = '0;
        line_if.stop_y      = '0;
        line_if.pixel_color = '0;
        pix_if.ready        = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: degenerate start, idle step, both directions, abandon
        add_cmd(MODE_START, 5, 5, 5, 5, 32'hDEAD_BEEF);
        add_steps(1);
        add_line(0, 0, 3, 1, 3);
        add_steps(1);
        add_cmd(MODE_START, COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX, 32'hFFFF_FFFF);
        add_steps(3);
        add_cmd(MODE_START, COORD_MAX, 0, COORD_MAX - 1, COORD_MAX, 32'h0000_0000);
        add_steps(2);
        add_line(0, COORD_MAX, 1, COORD_MAX - 2, 3);
        add_line(0, 0, COORD_MAX, COORD_MAX, 2);
        add_cmd(MODE_START, 9, 9, 9, 9, 32'h1234_5678);
        add_steps(1);

        // Random phases over a range of pitches, extremes included
        fill_random(PHASE_ITEMS);
        write_pitch(13'd4096);
        fill_random(PHASE_ITEMS);
        write_pitch(13'd1);
        fill_random(PHASE_ITEMS);
        write_pitch(13'd0);
        fill_random(PHASE_ITEMS);
        write_pitch(13'h1FFF);
        fill_random(PHASE_ITEMS);
        write_pitch(PITCH_W'($urandom_range(2, 4095)));
        fill_random(PHASE_ITEMS);

        while (pending_cmds.size() != 0 || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_pixels.size() != 0)
            fail_cnt++;
        $display("covered %0d line items (%0d starts) under %0d pitch settings",
                 items_sent, starts_sent, pitches_used);
        $display("got %0d pixels, %0d empty items, %0d line ends",
                 pixels_seen, empties_seen, line_ends);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Drive command items; hold an offered item until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            line_if.valid <= 1'b0;
        end else if (line_if.valid && !line_taken) begin
            // keep offering the same item
        end else if (pending_cmds.size() != 0 &&
                     ((items_sent >= 400 && items_sent < 600) ||
                      $urandom_range(0, 99) >= 20)) begin
            line_if.valid       <= 1'b1;
            line_if.mode        <= pending_cmds[0].mode;
            line_if.start_x     <= pending_cmds[0].sx;
            line_if.start_y     <= pending_cmds[0].sy;
            line_if.stop_x      <= pending_cmds[0].ex;
            line_if.stop_y      <= pending_cmds[0].ey;
            line_if.pixel_color <= pending_cmds[0].color;
        end else begin
            line_if.valid <= 1'b0;
        end
    end

    // Drive pixel ready: random stalls, one long hold-off, one quiet stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            pix_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!pressure_done && results_seen >= 250) begin
            pix_if.ready  <= 1'b0;
            hold_left     <= 80;
            pressure_done <= 1'b1;
        end else if (results_seen >= 400 && results_seen < 600) begin
            pix_if.ready <= 1'b1;
        end else begin
            pix_if.ready <= ($urandom_range(0, 99) >= 20);
        end
    end

    // Check pixel items, predict accepted commands, watch for a hang.
    t_pixel_res got_exp;
    t_line_cmd  got_cmd;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_if.valid && pix_if.ready) begin
                results_seen++;
                if (pix_if.pixel_valid)
                    pixels_seen++;
                else
                    empties_seen++;
                if (pix_if.last_pixel)
                    line_ends++;
                if (expected_pixels.size() == 0) begin
                    $error("pixel item with none expected: index %0h", pix_if.pixel_index);
                    fail_cnt++;
                end else begin
                    got_exp = expected_pixels.pop_front();
                    if (pix_if.pixel_valid !== got_exp.pix_valid) begin
                        $error("pixel_valid mismatch: expected %0b, got %0b",
                               got_exp.pix_valid, pix_if.pixel_valid);
                        fail_cnt++;
                    end
                    if (pix_if.pixel_index !== got_exp.index) begin
                        $error("pixel_index mismatch: expected %0h, got %0h",
                               got_exp.index, pix_if.pixel_index);
                        fail_cnt++;
                    end
                    if (pix_if.out_color !== got_exp.color) begin
                        $error("out_color mismatch: expected %0h, got %0h",
                               got_exp.color, pix_if.out_color);
                        fail_cnt++;
                    end
                    if (pix_if.last_pixel !== got_exp.last) begin
                        $error("last_pixel mismatch: expected %0b, got %0b",
                               got_exp.last, pix_if.last_pixel);
                        fail_cnt++;
                    end
                end
            end

            line_taken = line_if.valid && line_if.ready;
            if (line_taken) begin
                got_cmd = pending_cmds.pop_front();
                expected_pixels.push_back(walk_predict(got_cmd));
                items_sent++;
                if (got_cmd.mode == MODE_START)
                    starts_sent++;
            end

            if (line_taken || (pix_if.valid && pix_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("no item moved for %0d cycles, %0d pixel items outstanding",
                         stall_cycles, expected_pixels.size());
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
